>>> rtl/slrg_pkg.sv
// Shared types and constants of the subtractive lagged random generator.
// No dependencies; imported by slrg_scale and the core top level.
package slrg_pkg;

  // command codes carried by the cmd input
  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // table geometry
  typedef logic [5:0] slot_t;
  localparam slot_t LAG_LAST   = 6'd54;  // last slot of the 55-word table
  localparam slot_t FRONT_INIT = 6'd0;
  localparam slot_t BACK_INIT  = 6'd21;
  localparam slot_t MIX_OFFSET = 6'd31;  // partner slot of slot 0 in a mixing pass
  localparam logic [6:0] LAG_GAP = 7'd21;
  localparam logic [6:0] LAG_LEN = 7'd55;

  // word constants
  localparam logic [31:0] WORD_MAX    = 32'h7fff_ffff;
  localparam logic [31:0] SEED_BASE   = 32'd161803398;
  localparam logic [30:0] FOLD_MAX    = 31'h7fff_ffff;
  localparam logic [30:0] FOLD_MAX_M1 = 31'h7fff_fffe;

  // one item entering the scaling pipeline
  typedef struct packed {
    logic        valid;
    logic        not_seeded;
    logic [31:0] raw;
    logic [30:0] bound;
  } scale_req_t;

endpackage

>>> rtl/subtractive_lagged_random_generator_core.sv
// Draw: busy in the cycle after accept (DRAW state), then idle for the next item.
// Draw before any seed: busy stays low.
// Seed: busy through 55 table writes and 4 x 55 read/write mixing updates on the
// table memory. Results pass the scaling pipeline. The result strobe cannot be stalled.
// Reset (synchronous, active high) resets cursors, seeded flag and pipeline; table is unset.
// Depends on slrg_pkg and slrg_scale.
module subtractive_lagged_random_generator_core import slrg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic signed [31:0] seed,
  input  logic [30:0]        bound,
  output logic               done,
  output logic signed [31:0] raw_value,
  output logic signed [31:0] scaled_value,
  output logic               not_seeded
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DRAW   = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_MIX_RD = 3'd3;
  localparam logic [2:0] ST_MIX_WR = 3'd4;

  logic [2:0]  state, state_next;
  slot_t       fslot, bslot;
  logic        seeded;
  logic [30:0] bound_reg;
  logic [31:0] mj, mk;
  slot_t       fill_cnt, fill_slot;
  slot_t       ma, mb;
  logic [1:0]  pass;
  scale_req_t  req;
  logic        req_valid;
  logic        req_ns;
  logic [31:0] req_raw;
  logic [30:0] req_bound;

  logic [31:0] lag_mem [0:54];
  logic [31:0] qa, qb;
  slot_t       rd_a, rd_b;
  logic        wr_en;
  slot_t       wr_addr;
  logic [31:0] wr_data;

  logic        accept;
  logic [31:0] seed_mag;
  logic [31:0] draw_diff, draw_word;
  logic [31:0] mix_word;
  logic [31:0] fill_first;
  logic [6:0]  fill_sum;
  slot_t       fill_slot_next;
  logic        mix_last;

  function automatic logic [31:0] sub_fold(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    if (d[31]) begin
      d = d + WORD_MAX;
    end
    return d;
  endfunction

  function automatic slot_t slot_inc(input slot_t s);
    return (s == LAG_LAST) ? 6'd0 : s + 6'd1;
  endfunction

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // request to the scaling pipeline
  assign req = '{valid: req_valid, not_seeded: req_ns, raw: req_raw, bound: req_bound};

  // seed magnitude, most negative seed maps to the largest positive word
  always_comb begin
    if (seed == $signed(32'h8000_0000)) begin
      seed_mag = WORD_MAX;
    end else if (seed[31]) begin
      seed_mag = -seed;
    end else begin
      seed_mag = seed;
    end
  end

  // draw update: difference, pull max word down by one, fold negatives
  always_comb begin
    draw_diff = qa - qb;
    draw_word = draw_diff;
    if (draw_diff == WORD_MAX) begin
      draw_word = WORD_MAX - 32'd1;
    end
    if (draw_diff[31]) begin
      draw_word = draw_diff + WORD_MAX;
    end
  end

  assign mix_word   = sub_fold(qa, qb);
  assign fill_first = SEED_BASE - mj;
  assign mix_last   = (pass == 2'd3) && (ma == LAG_LAST);

  // scattered fill position advances by 21 modulo 55
  always_comb begin
    fill_sum = {1'b0, fill_slot} + LAG_GAP;
    if (fill_sum >= LAG_LEN) begin
      fill_sum = fill_sum - LAG_LEN;
    end
    fill_slot_next = fill_sum[5:0];
  end

  // memory port selection
  always_comb begin
    rd_a    = (state == ST_IDLE) ? fslot : ma;
    rd_b    = (state == ST_IDLE) ? bslot : mb;
    wr_en   = 1'b0;
    wr_addr = fslot;
    wr_data = draw_word;
    case (state)
      ST_DRAW: begin
        wr_en = 1'b1;
      end
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = (fill_cnt == 6'd0) ? LAG_LAST : fill_slot;
        wr_data = (fill_cnt == 6'd0) ? fill_first : mk;
      end
      ST_MIX_WR: begin
        wr_en   = 1'b1;
        wr_addr = ma;
        wr_data = mix_word;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // lag table, registered reads on two ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lag_mem[wr_addr] <= wr_data;
    end
    qa <= lag_mem[rd_a];
    qb <= lag_mem[rd_b];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && cmd == CMD_SEED) begin
          state_next = ST_FILL;
        end else if (accept && seeded) begin
          state_next = ST_DRAW;
        end
      end
      ST_DRAW:   state_next = ST_IDLE;
      ST_FILL:   state_next = (fill_cnt == LAG_LAST) ? ST_MIX_RD : ST_FILL;
      ST_MIX_RD: state_next = ST_MIX_WR;
      ST_MIX_WR: state_next = mix_last ? ST_IDLE : ST_MIX_RD;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fslot     <= FRONT_INIT;
      bslot     <= BACK_INIT;
      seeded    <= 1'b0;
      req_valid <= 1'b0;
    end else begin
      state     <= state_next;
      req_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          // draw before seed answers at once
          if (accept && cmd == CMD_DRAW && !seeded) begin
            req_valid <= 1'b1;
          end
        end
        ST_DRAW: begin
          fslot     <= slot_inc(fslot);
          bslot     <= slot_inc(bslot);
          req_valid <= 1'b1;
        end
        ST_MIX_WR: begin
          if (mix_last) begin
            fslot     <= FRONT_INIT;
            bslot     <= BACK_INIT;
            seeded    <= 1'b1;
            req_valid <= 1'b1;
          end
        end
        default: begin
          req_valid <= 1'b0;
        end
      endcase
    end
  end

  // seeding datapath and request payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        bound_reg <= bound;
        mj        <= seed_mag;
        fill_cnt  <= 6'd0;
        ma        <= 6'd0;
        mb        <= MIX_OFFSET;
        pass      <= 2'd0;
        req_raw   <= 32'd0;
        req_bound <= 31'd0;
        req_ns    <= 1'b1;
      end
      ST_DRAW: begin
        req_raw   <= draw_word;
        req_bound <= bound_reg;
        req_ns    <= 1'b0;
      end
      ST_FILL: begin
        fill_cnt <= fill_cnt + 6'd1;
        if (fill_cnt == 6'd0) begin
          mj        <= fill_first;
          mk        <= 32'd1;
          fill_slot <= BACK_INIT - 6'd1;
        end else begin
          mk        <= sub_fold(mj, mk);
          mj        <= mk;
          fill_slot <= fill_slot_next;
        end
      end
      ST_MIX_WR: begin
        ma <= slot_inc(ma);
        mb <= slot_inc(mb);
        if (ma == LAG_LAST) begin
          pass <= pass + 2'd1;
        end
        req_raw   <= 32'd0;
        req_bound <= 31'd0;
        req_ns    <= 1'b0;
      end
      default: begin
        mj <= mj;
      end
    endcase
  end

  slrg_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .done         (done),
    .raw_value    (raw_value),
    .scaled_value (scaled_value),
    .not_seeded   (not_seeded)
  );

  // cursors stay 21 slots apart inside the table
  a_cursor_gap: assert property (@(posedge clk) disable iff (rst)
    (fslot <= LAG_LAST) && (bslot <= LAG_LAST) &&
    ((({1'b0, fslot} + LAG_GAP) == {1'b0, bslot}) ||
     (({1'b0, bslot} + (LAG_LEN - LAG_GAP)) == {1'b0, fslot})))
    else $error("cursor spacing broken");

  // a seed item always occupies the table
  a_seed_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_SEED) |=> busy)
    else $error("seed did not start");

  // a draw before seeding leaves the table alone
  a_unseeded_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_DRAW && !seeded) |=> !busy)
    else $error("unseeded draw touched the table");

  // unseeded result carries zero values
  a_unseeded_zero: assert property (@(posedge clk) disable iff (rst)
    (done && not_seeded) |-> (raw_value == 32'sd0 && scaled_value == 32'sd0))
    else $error("unseeded result not zero");

endmodule

>>> rtl/slrg_scale.sv
// Scaling pipeline: raw * bound / 2147483647, truncated toward zero, five stages.
// Depends on slrg_pkg for the request struct and the fold constants.
module slrg_scale import slrg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  scale_req_t         req,
  output logic               done,
  output logic signed [31:0] raw_value,
  output logic signed [31:0] scaled_value,
  output logic               not_seeded
);

  logic               v1, v2, v3, v4;
  logic               ns1, ns2, ns3, ns4;
  logic [31:0]        raw1, raw2, raw3, raw4;
  logic signed [62:0] prod1;
  logic               neg2, neg3, neg4;
  logic [61:0]        mag2;
  logic [30:0]        hi3;
  logic [31:0]        sum3;
  logic [31:0]        q4;

  logic signed [63:0] prod_full;
  logic [62:0]        prod_neg;
  logic [61:0]        mag_next;
  logic [30:0]        l2;
  logic               h2;
  logic               corr;
  logic [31:0]        q_next;
  logic [31:0]        q_neg;

  // signed product of raw and the non-negative bound
  assign prod_full = $signed(req.raw) * $signed({1'b0, req.bound});

  // magnitude of the product, below 2^62
  assign prod_neg = -prod1;
  assign mag_next = prod1[62] ? prod_neg[61:0] : prod1[61:0];

  // division by (2^31-1) by folding: hi + lo, then one more carry and a final correction
  assign h2     = sum3[31];
  assign l2     = sum3[30:0];
  assign corr   = (l2 == FOLD_MAX) || ((l2 == FOLD_MAX_M1) && h2);
  assign q_next = {1'b0, hi3} + {31'b0, h2} + {31'b0, corr};
  assign q_neg  = -q4;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= req.valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    prod1 <= prod_full[62:0];
    ns1   <= req.not_seeded;
    raw1  <= req.raw;

    mag2 <= mag_next;
    neg2 <= prod1[62];
    ns2  <= ns1;
    raw2 <= raw1;

    hi3  <= mag2[61:31];
    sum3 <= {1'b0, mag2[61:31]} + {1'b0, mag2[30:0]};
    neg3 <= neg2;
    ns3  <= ns2;
    raw3 <= raw2;

    q4   <= q_next;
    neg4 <= neg3;
    ns4  <= ns3;
    raw4 <= raw3;

    scaled_value <= neg4 ? $signed(q_neg) : $signed(q4);
    raw_value    <= $signed(raw4);
    not_seeded   <= ns4;
  end

endmodule

>>> sim/tb.sv
// Self-checking testbench for subtractive_lagged_random_generator_core.
// Drives seed and draw items via start/busy, checks done results against typed-in
// values or an in-bench lagged-table model; depends on slrg_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import slrg_pkg::*;

  localparam int RST_CYCLES = 9;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_CYCLES = 20;

  // one expected or observed result
  typedef struct packed {
    logic [31:0] raw;
    logic [31:0] scaled;
    logic        not_seeded;
  } gen_result_t;

  // one directed item, with a typed-in result where it is obvious
  typedef struct packed {
    logic        cmd;
    logic [31:0] seed;
    logic [30:0] bound;
    logic        typed;
    logic [31:0] w_raw;
    logic [31:0] w_scaled;
    logic        w_ns;
  } stim_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               cmd = CMD_DRAW;
  logic signed [31:0] seed = '0;
  logic [30:0]        bound = '0;
  logic               busy;
  logic               done;
  logic signed [31:0] raw_value;
  logic signed [31:0] scaled_value;
  logic               not_seeded;

  subtractive_lagged_random_generator_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .seed         (seed),
    .bound        (bound),
    .done         (done),
    .raw_value    (raw_value),
    .scaled_value (scaled_value),
    .not_seeded   (not_seeded)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // model state of the generator
  logic [31:0] lag_words [55];
  int unsigned front_pos;
  int unsigned back_pos;
  bit          have_seed;

  gen_result_t pending_results [$];
  int          fail_count = 0;
  int          quiet_cycles = 0;

  // directed items: extremes of seed and bound, draws before any seed
  stim_row_t directed_rows [24] = '{
    '{CMD_DRAW, 32'h0000_0000, 31'h0,         1'b1, 32'h0, 32'h0, 1'b1},
    '{CMD_DRAW, 32'hffff_ffff, 31'h7fff_ffff, 1'b1, 32'h0, 32'h0, 1'b1},
    '{CMD_SEED, 32'h0000_0000, 31'h0,         1'b1, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'h0000_0000, 31'h7fff_ffff, 1'b0, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'h0000_0000, 31'h0,         1'b0, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'h0000_0000, 31'h1,         1'b0, 32'h0, 32'h0, 1'b0},
    '{CMD_SEED, 32'h8000_0000, 31'h0,         1'b1, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'h0000_0000, 31'h7fff_ffff, 1'b0, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'h0000_0000, 31'h2aaa_aaaa, 1'b0, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'h0000_0000, 31'h5555_5555, 1'b0, 32'h0, 32'h0, 1'b0},
    '{CMD_SEED, 32'h7fff_ffff, 31'h7fff_ffff, 1'b1, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'h0000_0000, 31'h7fff_ffff, 1'b0, 32'h0, 32'h0, 1'b0},
    '{CMD_SEED, 32'hffff_ffff, 31'h0,         1'b1, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'h0000_0000, 31'd1000,      1'b0, 32'h0, 32'h0, 1'b0},
    '{CMD_SEED, 32'h0000_0001, 31'h0,         1'b1, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'hffff_ffff, 31'h7fff_ffff, 1'b0, 32'h0, 32'h0, 1'b0},
    '{CMD_SEED, 32'd161803398, 31'h0,         1'b1, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'h0000_0000, 31'd12345,     1'b0, 32'h0, 32'h0, 1'b0},
    '{CMD_SEED, -32'sd161803398, 31'h0,       1'b1, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'h0000_0000, 31'h7fff_ffff, 1'b0, 32'h0, 32'h0, 1'b0},
    '{CMD_SEED, 32'haaaa_aaaa, 31'h5555_5555, 1'b1, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'h5555_5555, 31'h2aaa_aaaa, 1'b0, 32'h0, 32'h0, 1'b0},
    '{CMD_SEED, 32'h5555_5555, 31'h2aaa_aaaa, 1'b1, 32'h0, 32'h0, 1'b0},
    '{CMD_DRAW, 32'haaaa_aaaa, 31'h5555_5555, 1'b0, 32'h0, 32'h0, 1'b0}
  };

  // wrapping difference, folded once into range when negative
  function automatic logic [31:0] sub_wrap(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    if (d[31]) d = d + WORD_MAX;
    return d;
  endfunction

  // rebuild the lag table from a seed
  function automatic void rebuild_table(logic [31:0] s);
    logic [31:0] mag;
    logic [31:0] mj;
    logic [31:0] mk;
    int unsigned pos;
    int unsigned sl;
    int unsigned partner;
    if (s == 32'h8000_0000) mag = WORD_MAX;
    else if (s[31]) mag = -s;
    else mag = s;
    mj = SEED_BASE - mag;
    lag_words[54] = mj;
    mk = 32'd1;
    // scattered fill, 21 positions apart
    for (int unsigned i = 1; i < 55; i++) begin
      pos = (21 * i) % 55;
      sl = (pos == 0) ? 54 : pos - 1;
      lag_words[sl] = mk;
      mk = sub_wrap(mj, mk);
      mj = lag_words[sl];
    end
    // four mixing passes against the word 31 places on
    for (int k = 0; k < 4; k++) begin
      for (int unsigned i = 1; i <= 55; i++) begin
        partner = 1 + (i + 30) % 55;
        lag_words[i - 1] = sub_wrap(lag_words[i - 1], lag_words[partner - 1]);
      end
    end
    front_pos = 0;
    back_pos = 21;
    have_seed = 1'b1;
  endfunction

  // expected result of one item, updating the model state
  function automatic gen_result_t predict_gen_result(logic c, logic [31:0] s, logic [30:0] b);
    gen_result_t r;
    logic [31:0] d;
    longint      raw_s;
    longint      bnd;
    longint      span;
    r = '0;
    if (c == CMD_SEED) begin
      rebuild_table(s);
      return r;
    end
    if (!have_seed) begin
      r.not_seeded = 1'b1;
      return r;
    end
    front_pos = (front_pos + 1 > 55) ? 1 : front_pos + 1;
    back_pos = (back_pos + 1 > 55) ? 1 : back_pos + 1;
    d = lag_words[front_pos - 1] - lag_words[back_pos - 1];
    if (d == WORD_MAX) d = d - 1;
    if (d[31]) d = d + WORD_MAX;
    lag_words[front_pos - 1] = d;
    // exact scaling, truncated toward zero
    raw_s = signed'(d);
    bnd = longint'(b);
    span = longint'(WORD_MAX);
    r.raw = d;
    r.scaled = 32'(raw_s * bnd / span);
    return r;
  endfunction

  // offer one item until accepted, then record its expected result
  task automatic send_item(logic c, logic [31:0] s, logic [30:0] b, bit typed, gen_result_t want);
    gen_result_t pred;
    start <= 1'b1;
    cmd <= c;
    seed <= s;
    bound <= b;
    do @(posedge clk); while (busy);
    pred = predict_gen_result(c, s, b);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every pending result has come back
  task automatic wait_results_clear();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    gen_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending: raw_value %0d", raw_value);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (raw_value !== want.raw) begin
          $error("raw_value: expected %0d, got %0d", $signed(want.raw), raw_value);
          fail_count++;
        end
        if (scaled_value !== want.scaled) begin
          $error("scaled_value: expected %0d, got %0d", $signed(want.scaled), scaled_value);
          fail_count++;
        end
        if (not_seeded !== want.not_seeded) begin
          $error("not_seeded: expected %0b, got %0b", want.not_seeded, not_seeded);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with neither an item nor a result moving
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin : drive_items
    gen_result_t want;
    logic        c;
    logic [31:0] s;
    logic [30:0] b;
    front_pos = 0;
    back_pos = 21;
    have_seed = 1'b0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed items
    foreach (directed_rows[i]) begin
      want.raw = directed_rows[i].w_raw;
      want.scaled = directed_rows[i].w_scaled;
      want.not_seeded = directed_rows[i].w_ns;
      send_item(directed_rows[i].cmd, directed_rows[i].seed, directed_rows[i].bound,
                directed_rows[i].typed, want);
      if ($urandom_range(0, 99) < 33) idle_cycles($urandom_range(1, 6));
    end

    // random items, mostly draws with an occasional reseed
    want = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0 || n == 300 || n == 850) wait_results_clear();
      c = ($urandom_range(0, 99) < 4) ? CMD_SEED : CMD_DRAW;
      case ($urandom_range(0, 7))
        0: s = 32'h8000_0000;
        1: s = 32'h7fff_ffff;
        2: s = $urandom_range(0, 3) == 0 ? 32'hffff_ffff : 32'h0;
        default: s = $urandom();
      endcase
      case ($urandom_range(0, 7))
        0: b = '0;
        1: b = 31'h7fff_ffff;
        2: b = 31'($urandom_range(1, 100));
        default: b = 31'($urandom());
      endcase
      send_item(c, s, b, 1'b0, want);
      // no gaps between items 500 and 699
      if ((n < 500 || n >= 700) && $urandom_range(0, 99) < 33) begin
        idle_cycles($urandom_range(1, 6));
      end
    end

    // drain
    wait_results_clear();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
